// ===== hw/rtl/sfr_pkg.sv =====
// Shared types and constants for the streaming find-and-replace unit.
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned TEXT_W      = 64;
   localparam int unsigned LEN_W       = 4;

   localparam logic [7:0] NEWLINE = 8'd10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PATTERN_BYTES      = 2'd0,
      REG_PATTERN_LENGTH     = 2'd1,
      REG_REPLACEMENT_BYTES  = 2'd2,
      REG_REPLACEMENT_LENGTH = 2'd3
   } sfr_reg_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_stream;
   } sfr_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } sfr_rsp_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic       load;
      logic       shift;
      logic       clear;
      logic [7:0] load_byte;
   } sfr_cell_ctl_type;

   // what the chain reports back to the sequencer
   typedef struct packed {
      logic       head_valid;
      logic [7:0] head_byte;
      logic       all_ok;
      logic       full;
   } sfr_chain_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STALE,
      ST_SCAN,
      ST_REPL,
      ST_FLUSH,
      ST_END
   } sfr_state_type;

endpackage

// ===== hw/rtl/sfr_cell.sv =====
// One pending-byte cell: holds a byte, compares it with its pattern byte.
`timescale 1ns / 1ps

module sfr_cell #(
   parameter int unsigned INDEX = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sfr_pkg::sfr_cell_ctl_type ctl,
   input  logic [7:0]               pat_byte,
   input  logic [sfr_pkg::LEN_W-1:0] plen,
   input  logic                     left_valid,
   input  logic [7:0]               right_byte,
   input  logic                     right_valid,
   input  logic                     ok_in,
   input  logic                     full_in,
   output logic                     ok_out,
   output logic                     full_out,
   output logic [7:0]               byte_out,
   output logic                     valid_out
);

   localparam logic [sfr_pkg::LEN_W-1:0] IDX = sfr_pkg::LEN_W'(INDEX);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       own_ok;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      priority if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.shift) begin
         valid_in = right_valid;
         byte_in  = right_byte;
      end else if (ctl.load && !valid_ff && left_valid) begin
         // new word lands in the first free cell
         valid_in = 1'b1;
         byte_in  = ctl.load_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign own_ok    = !valid_ff || (IDX >= plen) || (byte_ff == pat_byte);
   assign ok_out    = ok_in && own_ok;
   assign full_out  = full_in || (valid_ff && ((IDX + 4'd1) == plen));
   assign byte_out  = byte_ff;
   assign valid_out = valid_ff;

endmodule

// ===== hw/rtl/sfr_ctrl.sv =====
// Sequencer: drives the cell chain, replacement emission and the output stage.
`timescale 1ns / 1ps

module sfr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  sfr_pkg::sfr_req_type          req_data,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sfr_pkg::sfr_rsp_type          rsp_data,
   output sfr_pkg::sfr_cell_ctl_type     cell_ctl,
   input  sfr_pkg::sfr_chain_stat_type   chain_stat,
   input  logic [sfr_pkg::LEN_W-1:0]     plen,
   input  logic [sfr_pkg::LEN_W-1:0]     rlen,
   input  logic [sfr_pkg::TEXT_W-1:0]    repl_bytes,
   input  logic                          pattern_write
);

   localparam int unsigned TEXT_W_SH = sfr_pkg::TEXT_W;

   sfr_pkg::sfr_state_type state_ff, state_in;

   logic       stale_ff, stale_in;
   logic       flush_ff, flush_in;
   logic [7:0] hold_ff, hold_in;
   logic [2:0] rep_cnt_ff, rep_cnt_in;
   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_byte_ff, stage_byte_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;

   logic       out_free, can_emit, emit, push_last;
   logic [7:0] emit_byte, repl_byte;
   logic [TEXT_W_SH-1:0] repl_shifted;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign can_emit  = !stage_valid_ff || out_free;
   assign repl_shifted = repl_bytes >> {rep_cnt_ff, 3'b000};
   assign repl_byte = repl_shifted[7:0];

   always_comb begin
      state_in   = state_ff;
      stale_in   = stale_ff;
      flush_in   = flush_ff;
      hold_in    = hold_ff;
      rep_cnt_in = rep_cnt_ff;
      cell_ctl   = '0;
      emit       = 1'b0;
      emit_byte  = chain_stat.head_byte;
      push_last  = 1'b0;
      req_stall  = (state_ff != sfr_pkg::ST_IDLE);

      unique case (state_ff)
         sfr_pkg::ST_IDLE: begin
            if (pattern_write && chain_stat.head_valid) begin
               stale_in = 1'b1;
            end
            if (req_valid) begin
               hold_in  = req_data.in_byte;
               flush_in = (req_data.in_byte == sfr_pkg::NEWLINE) || req_data.end_of_stream;
               if (stale_ff) begin
                  state_in = sfr_pkg::ST_STALE;
               end else begin
                  cell_ctl.load      = 1'b1;
                  cell_ctl.load_byte = req_data.in_byte;
                  state_in           = sfr_pkg::ST_SCAN;
               end
            end
         end
         sfr_pkg::ST_STALE: begin
            // held bytes from the old pattern go out unmatched first
            if (chain_stat.head_valid) begin
               if (can_emit) begin
                  emit           = 1'b1;
                  cell_ctl.shift = 1'b1;
               end
            end else begin
               cell_ctl.load      = 1'b1;
               cell_ctl.load_byte = hold_ff;
               stale_in           = 1'b0;
               state_in           = sfr_pkg::ST_SCAN;
            end
         end
         sfr_pkg::ST_SCAN: begin
            if (!chain_stat.head_valid) begin
               state_in = sfr_pkg::ST_END;
            end else if ((plen == '0) || !chain_stat.all_ok) begin
               if (can_emit) begin
                  emit           = 1'b1;
                  cell_ctl.shift = 1'b1;
               end
            end else if (chain_stat.full) begin
               cell_ctl.clear = 1'b1;
               rep_cnt_in     = '0;
               state_in       = (rlen == '0) ? sfr_pkg::ST_END : sfr_pkg::ST_REPL;
            end else begin
               // partial match: keep it unless the line or stream ends
               state_in = flush_ff ? sfr_pkg::ST_FLUSH : sfr_pkg::ST_END;
            end
         end
         sfr_pkg::ST_REPL: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_byte = repl_byte;
               if ({1'b0, rep_cnt_ff} == (rlen - 4'd1)) begin
                  state_in = sfr_pkg::ST_END;
               end else begin
                  rep_cnt_in = rep_cnt_ff + 3'd1;
               end
            end
         end
         sfr_pkg::ST_FLUSH: begin
            if (chain_stat.head_valid) begin
               if (can_emit) begin
                  emit           = 1'b1;
                  cell_ctl.shift = 1'b1;
               end
            end else begin
               state_in = sfr_pkg::ST_END;
            end
         end
         sfr_pkg::ST_END: begin
            if (!stage_valid_ff) begin
               state_in = sfr_pkg::ST_IDLE;
            end else if (out_free) begin
               push_last = 1'b1;
               state_in  = sfr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sfr_pkg::ST_IDLE;
         end
      endcase
   end

   // one-word staging holds back each result until it is known whether it is the last
   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_byte_in  = stage_byte_ff;
      out_valid_in   = out_valid_ff && rsp_stall;
      out_byte_in    = out_byte_ff;
      out_last_in    = out_last_ff;
      if (emit) begin
         stage_valid_in = 1'b1;
         stage_byte_in  = emit_byte;
         if (stage_valid_ff) begin
            out_valid_in = 1'b1;
            out_byte_in  = stage_byte_ff;
            out_last_in  = 1'b0;
         end
      end else if (push_last) begin
         stage_valid_in = 1'b0;
         out_valid_in   = 1'b1;
         out_byte_in    = stage_byte_ff;
         out_last_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sfr_pkg::ST_IDLE;
         stale_ff       <= 1'b0;
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         stale_ff       <= stale_in;
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
      flush_ff      <= flush_in;
      hold_ff       <= hold_in;
      rep_cnt_ff    <= rep_cnt_in;
      stage_byte_ff <= stage_byte_in;
      out_byte_ff   <= out_byte_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_data.out_byte = out_byte_ff;
   assign rsp_data.run_last = out_last_ff;

endmodule

// ===== hw/rtl/stream_find_replace_unit.sv =====
// Top level: configuration registers, pending-byte cell chain and sequencer.
// Each input word is handled in full before the next is taken: stale held bytes go out first,
//   then the match is checked, and a replacement is emitted or a partial match flushed.
// A stalled output stalls the sequencer; the next input is taken once idle.
// Reset (synchronous): chain empty, registers zero, pass-through mode.
`timescale 1ns / 1ps

module stream_find_replace_unit #(
   parameter int unsigned MAX_TEXT_BYTES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sfr_pkg::sfr_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sfr_pkg::sfr_rsp_type                rsp_data,
   input  logic                                csr_write_en,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam logic [sfr_pkg::LEN_W-1:0] MAX_LEN = sfr_pkg::LEN_W'(MAX_TEXT_BYTES);

   logic [sfr_pkg::TEXT_W-1:0] pattern_ff, pattern_in;
   logic [sfr_pkg::TEXT_W-1:0] repl_ff, repl_in;
   logic [sfr_pkg::LEN_W-1:0]  plen_ff, plen_in;
   logic [sfr_pkg::LEN_W-1:0]  rlen_ff, rlen_in;
   logic [sfr_pkg::LEN_W-1:0]  plen_eff, rlen_eff;
   logic                       pattern_write;

   sfr_pkg::sfr_cell_ctl_type   cell_ctl;
   sfr_pkg::sfr_chain_stat_type chain_stat;

   logic       valid_link [MAX_TEXT_BYTES+1];
   logic [7:0] byte_link  [MAX_TEXT_BYTES+1];
   logic       ok_link    [MAX_TEXT_BYTES+1];
   logic       full_link  [MAX_TEXT_BYTES+1];

   always_comb begin
      pattern_in = pattern_ff;
      repl_in    = repl_ff;
      plen_in    = plen_ff;
      rlen_in    = rlen_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            sfr_pkg::REG_PATTERN_BYTES:      pattern_in = csr_wdata;
            sfr_pkg::REG_PATTERN_LENGTH:     plen_in    = csr_wdata[sfr_pkg::LEN_W-1:0];
            sfr_pkg::REG_REPLACEMENT_BYTES:  repl_in    = csr_wdata;
            sfr_pkg::REG_REPLACEMENT_LENGTH: rlen_in    = csr_wdata[sfr_pkg::LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         repl_ff    <= '0;
         plen_ff    <= '0;
         rlen_ff    <= '0;
      end else begin
         pattern_ff <= pattern_in;
         repl_ff    <= repl_in;
         plen_ff    <= plen_in;
         rlen_ff    <= rlen_in;
      end
   end

   assign plen_eff = (plen_ff > MAX_LEN) ? MAX_LEN : plen_ff;
   assign rlen_eff = (rlen_ff > MAX_LEN) ? MAX_LEN : rlen_ff;

   assign pattern_write = csr_write_en &&
                          ((csr_index == sfr_pkg::REG_PATTERN_BYTES) ||
                           (csr_index == sfr_pkg::REG_PATTERN_LENGTH));

   // ends of the chain
   assign valid_link[MAX_TEXT_BYTES] = 1'b0;
   assign byte_link[MAX_TEXT_BYTES]  = 8'd0;
   assign ok_link[0]                 = 1'b1;
   assign full_link[0]               = 1'b0;

   for (genvar i = 0; i < MAX_TEXT_BYTES; i++) begin : g_cell
      logic left_valid;
      logic ok_out, full_out;

      if (i == 0) begin : g_head
         assign left_valid = 1'b1;
      end else begin : g_body
         assign left_valid = valid_link[i-1];
      end

      sfr_cell #(
         .INDEX(i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .pat_byte   (pattern_ff[8*i +: 8]),
         .plen       (plen_eff),
         .left_valid (left_valid),
         .right_byte (byte_link[i+1]),
         .right_valid(valid_link[i+1]),
         .ok_in      (ok_link[i]),
         .full_in    (full_link[i]),
         .ok_out     (ok_out),
         .full_out   (full_out),
         .byte_out   (byte_link[i]),
         .valid_out  (valid_link[i])
      );

      assign ok_link[i+1]   = ok_out;
      assign full_link[i+1] = full_out;
   end

   assign chain_stat.head_valid = valid_link[0];
   assign chain_stat.head_byte  = byte_link[0];
   assign chain_stat.all_ok     = ok_link[MAX_TEXT_BYTES];
   assign chain_stat.full       = full_link[MAX_TEXT_BYTES];

   sfr_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_data     (req_data),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .cell_ctl     (cell_ctl),
      .chain_stat   (chain_stat),
      .plen         (plen_eff),
      .rlen         (rlen_eff),
      .repl_bytes   (repl_ff),
      .pattern_write(pattern_write)
   );

endmodule

// ===== sim/stream_find_replace_tb.sv =====
// Testbench for the streaming find-and-replace unit: directed table then random phases.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned RANDOM_WORDS  = 336;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned MAX_TEXT      = 8;

   typedef enum logic {ROW_CSR, ROW_WORD} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      sfr_pkg::sfr_reg_type index;
      logic [63:0]          value;
      logic                 eos;
      logic                 typed;
      logic [7:0]           typed_byte;
   } stim_row_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} stall_mode_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   sfr_pkg::sfr_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   sfr_pkg::sfr_rsp_type rsp_data;
   logic                 csr_write_en;
   sfr_pkg::sfr_reg_type csr_index;
   logic [63:0]          csr_wdata;

   // predictor state
   logic [63:0] pat_q;
   logic [3:0]  pat_len_q;
   logic [63:0] rep_q;
   logic [3:0]  rep_len_q;
   logic [7:0]  carry_bytes [0:MAX_TEXT-2];
   int unsigned carry_count;
   bit          carry_outdated;

   sfr_pkg::sfr_rsp_type expected_text [$];

   int unsigned cycle_count     = 0;
   int unsigned mismatches      = 0;
   int unsigned words_sent      = 0;
   int unsigned results_checked = 0;
   int unsigned csr_writes      = 0;
   int unsigned match_count     = 0;
   int unsigned stale_releases  = 0;
   int unsigned burst_left      = 0;
   bit          steady          = 0;
   bit          busy            = 0;

   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    stall_left = 0;

   stim_row_type directed_rows [34] = '{
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'h00,     1'b0, 1'b1, 8'h00}, // pass-through
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'hFF,     1'b1, 1'b1, 8'hFF},
      '{ROW_CSR,  sfr_pkg::REG_PATTERN_BYTES,      64'h6261,   1'b0, 1'b0, 8'h00},
      '{ROW_CSR,  sfr_pkg::REG_PATTERN_LENGTH,     64'd2,      1'b0, 1'b0, 8'h00},
      '{ROW_CSR,  sfr_pkg::REG_REPLACEMENT_BYTES,  64'h5A5958, 1'b0, 1'b0, 8'h00},
      '{ROW_CSR,  sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd3,      1'b0, 1'b0, 8'h00},
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'h61,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'h62,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'h61,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'h61,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'h78,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'h61,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'h0A,     1'b0, 1'b0, 8'h00}, // newline flush
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'h61,     1'b1, 1'b0, 8'h00}, // end of stream
      '{ROW_CSR,  sfr_pkg::REG_PATTERN_BYTES,      '1,         1'b0, 1'b0, 8'h00},
      '{ROW_CSR,  sfr_pkg::REG_PATTERN_LENGTH,     64'd15,     1'b0, 1'b0, 8'h00}, // saturates
      '{ROW_CSR,  sfr_pkg::REG_REPLACEMENT_BYTES,  64'h0,      1'b0, 1'b0, 8'h00},
      '{ROW_CSR,  sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd15,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'hFF,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'hFF,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'hFF,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'hFF,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'hFF,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'hFF,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'hFF,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'hFF,     1'b0, 1'b0, 8'h00},
      '{ROW_CSR,  sfr_pkg::REG_PATTERN_LENGTH,     64'd2,      1'b0, 1'b0, 8'h00},
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'hFF,     1'b0, 1'b0, 8'h00}, // held
      '{ROW_CSR,  sfr_pkg::REG_REPLACEMENT_LENGTH, 64'd0,      1'b0, 1'b0, 8'h00},
      '{ROW_CSR,  sfr_pkg::REG_PATTERN_BYTES,      64'h0A00,   1'b0, 1'b0, 8'h00}, // held goes stale
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'h00,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'h0A,     1'b0, 1'b0, 8'h00}, // match deleted
      '{ROW_CSR,  sfr_pkg::REG_PATTERN_LENGTH,     64'd0,      1'b0, 1'b0, 8'h00},
      '{ROW_WORD, sfr_pkg::REG_PATTERN_BYTES,      64'h41,     1'b0, 1'b1, 8'h41}
   };

   stream_find_replace_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // rewritten text for one input byte; updates the carried bytes
   function automatic void rewrite_byte(input logic [7:0] b, input logic eos,
                                        ref sfr_pkg::sfr_rsp_type words [$]);
      logic [7:0]  run [0:MAX_TEXT];
      int unsigned plen, rlen, n, s, m, i, left;
      bit          hit;
      plen = (pat_len_q > MAX_TEXT) ? MAX_TEXT : pat_len_q;
      rlen = (rep_len_q > MAX_TEXT) ? MAX_TEXT : rep_len_q;
      words.delete();
      if (carry_outdated) begin
         for (i = 0; i < carry_count; i++)
            words.push_back('{out_byte: carry_bytes[i], run_last: 1'b0});
         carry_count    = 0;
         carry_outdated = 0;
         stale_releases++;
      end
      for (i = 0; i < carry_count; i++) run[i] = carry_bytes[i];
      run[carry_count] = b;
      n = carry_count + 1;
      s = 0;
      while (s < n) begin
         if (plen == 0) begin
            words.push_back('{out_byte: run[s], run_last: 1'b0});
            s++;
         end else begin
            left = n - s;
            m    = (left < plen) ? left : plen;
            hit  = 1;
            for (i = 0; i < m; i++)
               if (run[s+i] != pat_q[8*i +: 8]) hit = 0;
            if (hit && left >= plen) begin
               for (i = 0; i < rlen; i++)
                  words.push_back('{out_byte: rep_q[8*i +: 8], run_last: 1'b0});
               s += plen;
               match_count++;
            end else if (hit) begin
               break;
            end else begin
               words.push_back('{out_byte: run[s], run_last: 1'b0});
               s++;
            end
         end
      end
      left = n - s;
      if (b == sfr_pkg::NEWLINE || eos) begin
         for (i = 0; i < left; i++)
            words.push_back('{out_byte: run[s+i], run_last: 1'b0});
         left = 0;
      end
      for (i = 0; i < left; i++) carry_bytes[i] = run[s+i];
      carry_count = left;
      if (words.size() != 0) words[words.size()-1].run_last = 1'b1;
   endfunction

   function automatic void note_csr(input sfr_pkg::sfr_reg_type idx,
                                    input logic [63:0] value);
      unique case (idx)
         sfr_pkg::REG_PATTERN_BYTES: begin
            pat_q = value;
            if (carry_count != 0) carry_outdated = 1;
         end
         sfr_pkg::REG_PATTERN_LENGTH: begin
            pat_len_q = value[3:0];
            if (carry_count != 0) carry_outdated = 1;
         end
         sfr_pkg::REG_REPLACEMENT_BYTES:  rep_q = value;
         sfr_pkg::REG_REPLACEMENT_LENGTH: rep_len_q = value[3:0];
      endcase
   endfunction

   // mostly bytes of the live pattern, so partial matches keep forming
   function automatic logic [7:0] text_byte();
      int unsigned plen;
      plen = (pat_len_q > MAX_TEXT) ? MAX_TEXT : pat_len_q;
      if (plen != 0 && $urandom_range(0, 9) < 7)
         return pat_q[8*$urandom_range(0, plen-1) +: 8];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0d] mismatch: %s", cycle_count, msg);
   endfunction

   // pause the sender until every result is back and the block has gone quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      busy       = 0;
      burst_left = 0;
   endtask

   task automatic csr_write(input sfr_pkg::sfr_reg_type idx, input logic [63:0] value);
      if (busy) settle();
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      note_csr(idx, value);
      @(negedge clock);
      csr_write_en <= 1'b0;
      csr_writes++;
   endtask

   task automatic push_word(input logic [7:0] b, input logic eos,
                            input bit typed = 0, input logic [7:0] typed_byte = 8'h00);
      sfr_pkg::sfr_rsp_type got [$];
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = steady ? 0 : $urandom_range(0, 6);
         burst_left = $urandom_range(1, 12);
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      busy = 1;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= '{in_byte: b, end_of_stream: eos};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      rewrite_byte(b, eos, got);
      if (typed) expected_text.push_back('{out_byte: typed_byte, run_last: 1'b1});
      else foreach (got[i]) expected_text.push_back(got[i]);
   endtask

   // receiver stall pattern: a new random mode is drawn whenever the current one runs out
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      unique case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 1) == 0);
         STALL_BURSTY: rsp_stall <= ((stall_left % 12) < 9);
      endcase
   end

   always @(posedge clock) begin
      sfr_pkg::sfr_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (expected_text.size() == 0) begin
            flag_mismatch($sformatf("unexpected word byte=%h last=%b",
                                    rsp_data.out_byte, rsp_data.run_last));
         end else begin
            want = expected_text.pop_front();
            if (rsp_data.out_byte !== want.out_byte || rsp_data.run_last !== want.run_last)
               flag_mismatch($sformatf("byte exp %h got %h, last exp %b got %b",
                                       want.out_byte, rsp_data.out_byte,
                                       want.run_last, rsp_data.run_last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d words outstanding",
                  cycle_count, expected_text.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned random_start, n, k, i, r, plen, cut;
      bit          first;
      logic [7:0]  a0, a1;
      logic [63:0] pat;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_write_en = 1'b0;
      csr_index    = sfr_pkg::REG_PATTERN_BYTES;
      csr_wdata    = '0;
      pat_q          = '0;
      pat_len_q      = '0;
      rep_q          = '0;
      rep_len_q      = '0;
      carry_count    = 0;
      carry_outdated = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[j]) begin
         if (directed_rows[j].kind == ROW_CSR)
            csr_write(directed_rows[j].index, directed_rows[j].value);
         else
            push_word(directed_rows[j].value[7:0], directed_rows[j].eos,
                      directed_rows[j].typed, directed_rows[j].typed_byte);
      end

      random_start = words_sent;
      first        = 1;
      while (words_sent < random_start + RANDOM_WORDS) begin
         steady = ($urandom_range(0, 3) == 0);
         a0 = 8'($urandom_range(0, 255));
         a1 = ($urandom_range(0, 7) == 0) ? sfr_pkg::NEWLINE : 8'($urandom_range(0, 255));
         r  = $urandom_range(0, 9);
         plen = (r == 0) ? 0 : (r == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8);
         for (i = 0; i < 8; i++)
            pat[8*i +: 8] = (i < plen) ? ($urandom_range(0, 1) ? a0 : a1)
                                       : 8'($urandom_range(0, 255));
         // a pattern write while bytes are held marks them stale
         if (first || $urandom_range(0, 3) != 0)
            csr_write(sfr_pkg::REG_PATTERN_BYTES, pat);
         if (first || $urandom_range(0, 3) != 0)
            csr_write(sfr_pkg::REG_PATTERN_LENGTH, 64'(plen));
         if (first || $urandom_range(0, 3) != 0)
            csr_write(sfr_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
         if (first || $urandom_range(0, 3) != 0)
            csr_write(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'($urandom_range(0, 15)));
         first = 0;

         plen = (pat_len_q > MAX_TEXT) ? MAX_TEXT : pat_len_q;
         n    = $urandom_range(12, 36);
         k    = 0;
         while (k < n) begin
            r = $urandom_range(0, 99);
            if (r < 35 && plen > 0) begin
               for (i = 0; i < plen; i++) push_word(pat_q[8*i +: 8], 1'b0);
               k += plen;
            end else if (r < 55 && plen > 1) begin
               // partial match broken off, forcing a recheck of held bytes
               cut = $urandom_range(1, plen - 1);
               for (i = 0; i < cut; i++) push_word(pat_q[8*i +: 8], 1'b0);
               push_word(text_byte(), 1'b0);
               k += cut + 1;
            end else if (r < 85) begin
               push_word(text_byte(), 1'b0);
               k++;
            end else if (r < 93) begin
               push_word(sfr_pkg::NEWLINE, 1'b0);
               k++;
            end else begin
               push_word(text_byte(), 1'b1);
               k++;
            end
         end
      end

      settle();
      $display("Sent %0d text words (%0d directed) across %0d register writes;",
               words_sent, random_start, csr_writes);
      $display("%0d matches replaced, %0d stale held runs released, %0d result words checked",
               match_count, stale_releases, results_checked);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches in total", mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
